@@ rtl/tpfe_pkg.sv @@
// ----------------------------------------------------------------------------
// tpfe_pkg
// Shared types and constants for the tape pulse frame encoder.
// ----------------------------------------------------------------------------
package tpfe_pkg;

	// command codes on the input channel
	typedef enum logic [2:0] {
		CMD_TUNE      = 3'd0,
		CMD_LONG_MARK = 3'd1,
		CMD_GAP_MARK  = 3'd2,
		CMD_ONE_BIT   = 3'd3,
		CMD_BYTE      = 3'd4,
		CMD_CHK_BYTE  = 3'd5,
		CMD_EMIT_SUM  = 3'd6
	} cmd_t;

	// how the serialiser walks a job
	typedef enum logic {
		MODE_CYCLE = 1'b0, // alternate high/low at a fixed multiple
		MODE_BITS  = 1'b1  // four records per payload bit, LSB first
	} mode_t;

	localparam int UNIT_BITS = 12;
	localparam int SUM_BITS  = 16;
	localparam int IDX_BITS  = 6;   // up to 64 records per job
	localparam int BASE_BITS = 15;  // unit times eight

	localparam logic [UNIT_BITS-1:0] UNIT_RESET = 12'd1000;

	// unit multiple as a left shift: 1u, 2u, 4u, 8u
	localparam logic [1:0] SHIFT_1U = 2'd0;
	localparam logic [1:0] SHIFT_2U = 2'd1;
	localparam logic [1:0] SHIFT_4U = 2'd2;
	localparam logic [1:0] SHIFT_8U = 2'd3;

	// last record index per job kind
	localparam logic [IDX_BITS-1:0] LAST_ONE_REC   = 6'd0;
	localparam logic [IDX_BITS-1:0] LAST_CYCLE     = 6'd1;
	localparam logic [IDX_BITS-1:0] LAST_BIT       = 6'd3;
	localparam logic [IDX_BITS-1:0] LAST_BYTE      = 6'd31;
	localparam logic [IDX_BITS-1:0] LAST_TWO_BYTES = 6'd63;

	typedef struct packed {
		mode_t                 mode;
		logic [1:0]            shift;
		logic [IDX_BITS-1:0]   last_idx;
		logic [SUM_BITS-1:0]   payload;
	} job_t;

endpackage

@@ rtl/tpfe_cmd_if.sv @@
// ----------------------------------------------------------------------------
// tpfe_cmd_if
// Command channel: one command and its data byte per transaction.
// ----------------------------------------------------------------------------
interface tpfe_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] cmd;
	logic [7:0] data_byte;

	modport source (output valid, output cmd, output data_byte, input ready);
	modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

@@ rtl/tpfe_rec_if.sv @@
// ----------------------------------------------------------------------------
// tpfe_rec_if
// Pulse record channel: level, duration and end-of-run flag.
// ----------------------------------------------------------------------------
interface tpfe_rec_if #(
	parameter int DURATION_BITS = 15
);
	logic                     valid;
	logic                     ready;
	logic                     level;
	logic [DURATION_BITS-1:0] duration;
	logic                     last;

	modport source (output valid, output level, output duration, output last, input ready);
	modport sink   (input valid, input level, input duration, input last, output ready);
endinterface

@@ rtl/tpfe_cfg_if.sv @@
// ----------------------------------------------------------------------------
// tpfe_cfg_if
// Configuration write channel for the unit length register.
// ----------------------------------------------------------------------------
interface tpfe_cfg_if;
	logic        valid;
	logic        ready;
	logic [11:0] unit_length;

	modport source (output valid, output unit_length, input ready);
	modport sink   (input valid, input unit_length, output ready);
endinterface

@@ rtl/tape_pulse_frame_encoder_core.sv @@
// ----------------------------------------------------------------------------
// tape_pulse_frame_encoder_core
// Encodes tape commands into runs of pulse records (level, duration).
// ----------------------------------------------------------------------------
//
//  channel  | role   | payload                          | transaction
//  ---------+--------+----------------------------------+--------------------
//  cmd_ch   | sink   | cmd[2:0], data_byte[7:0]         | one command
//  rec_ch   | source | level, duration[DURATION_BITS], last | one pulse record
//  cfg_ch   | sink   | unit_length[11:0]                | unit length write
//
//  One pulse record leaves per cycle while rec_ch is not stalled. Records
//  per command: tune 2, long marker 1, gap marker 2, one bit 4, byte 32,
//  emit checksum 64, unused code 0; the serialiser sets a byte stream's pace.
//  A two-entry job queue lets the front take new commands while the
//  serialiser is busy; cmd_ch stalls only when the queue is full.
//  rec_ch is driven from a register; a stall holds it and the serialiser.
//  arst_n clears the checksum, the queue and the output valid, and sets the
//  unit length to 1000. cfg_ch is always ready.
//
module tape_pulse_frame_encoder_core #(
	parameter int DURATION_BITS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	tpfe_cmd_if.sink    cmd_ch,
	tpfe_cfg_if.sink    cfg_ch,
	tpfe_rec_if.source  rec_ch
);

	// front -> queue
	logic           push;
	tpfe_pkg::job_t push_job;
	logic           full;

	// queue -> serialiser
	logic           head_valid;
	tpfe_pkg::job_t head;
	logic           pop;

	// classify, keep the end-around-carry checksum
	tpfe_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.full   (full),
		.push   (push),
		.job    (push_job)
	);

	tpfe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	// record generator and output register
	tpfe_back #(
		.DURATION_BITS (DURATION_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_ch     (cfg_ch),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rec_ch     (rec_ch)
	);

endmodule

@@ rtl/tpfe_front.sv @@
// ----------------------------------------------------------------------------
// tpfe_front
// Accepts commands, keeps the checksum and turns each command into a job.
// ----------------------------------------------------------------------------
module tpfe_front (
	input  logic              clk,
	input  logic              arst_n,
	tpfe_cmd_if.sink          cmd_ch,
	input  logic              full,
	output logic              push,
	output tpfe_pkg::job_t    job
);

	logic [tpfe_pkg::SUM_BITS-1:0] sum_q;
	logic [tpfe_pkg::SUM_BITS:0]   add_raw;
	logic [tpfe_pkg::SUM_BITS-1:0] add_fold;
	logic                          accept;
	logic                          known;

	assign cmd_ch.ready = !full;
	assign accept       = cmd_ch.valid && cmd_ch.ready;

	// end-around carry: a carry out of bit 15 comes back in at bit 0
	assign add_raw  = {1'b0, sum_q} + {9'd0, cmd_ch.data_byte};
	assign add_fold = add_raw[tpfe_pkg::SUM_BITS-1:0] + {15'd0, add_raw[tpfe_pkg::SUM_BITS]};

	always_comb begin
		job.mode     = tpfe_pkg::MODE_CYCLE;
		job.shift    = tpfe_pkg::SHIFT_1U;
		job.last_idx = tpfe_pkg::LAST_CYCLE;
		job.payload  = {8'd0, cmd_ch.data_byte};
		known        = 1'b1;
		case (tpfe_pkg::cmd_t'(cmd_ch.cmd))
			tpfe_pkg::CMD_TUNE: begin
			end
			tpfe_pkg::CMD_LONG_MARK: begin
				job.shift    = tpfe_pkg::SHIFT_8U;
				job.last_idx = tpfe_pkg::LAST_ONE_REC;
			end
			tpfe_pkg::CMD_GAP_MARK: begin
				job.shift = tpfe_pkg::SHIFT_4U;
			end
			tpfe_pkg::CMD_ONE_BIT: begin
				job.mode     = tpfe_pkg::MODE_BITS;
				job.last_idx = tpfe_pkg::LAST_BIT;
				job.payload  = 16'd1;
			end
			tpfe_pkg::CMD_BYTE, tpfe_pkg::CMD_CHK_BYTE: begin
				job.mode     = tpfe_pkg::MODE_BITS;
				job.last_idx = tpfe_pkg::LAST_BYTE;
			end
			tpfe_pkg::CMD_EMIT_SUM: begin
				job.mode     = tpfe_pkg::MODE_BITS;
				job.last_idx = tpfe_pkg::LAST_TWO_BYTES;
				job.payload  = sum_q;
			end
			default: begin
				known = 1'b0; // unused code: no records
			end
		endcase
	end

	assign push = accept && known;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (accept) begin
			if (cmd_ch.cmd == tpfe_pkg::CMD_CHK_BYTE) begin
				sum_q <= add_fold;
			end else if (cmd_ch.cmd == tpfe_pkg::CMD_EMIT_SUM) begin
				sum_q <= '0;
			end
		end
	end

endmodule

@@ rtl/tpfe_queue.sv @@
// ----------------------------------------------------------------------------
// tpfe_queue
// Two-entry job queue between the front and the serialiser.
// ----------------------------------------------------------------------------
module tpfe_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tpfe_pkg::job_t    push_job,
	input  logic              pop,
	output logic              full,
	output logic              head_valid,
	output tpfe_pkg::job_t    head
);

	tpfe_pkg::job_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

@@ rtl/tpfe_back.sv @@
// ----------------------------------------------------------------------------
// tpfe_back
// Pulse serialiser: walks the head job one record per cycle into the
// output register unless rec_ch stalls. Also holds the unit length register.
// ----------------------------------------------------------------------------
module tpfe_back #(
	parameter int DURATION_BITS = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	tpfe_cfg_if.sink          cfg_ch,
	input  logic              head_valid,
	input  tpfe_pkg::job_t    head,
	output logic              pop,
	tpfe_rec_if.source        rec_ch
);

	localparam int WIDE = (DURATION_BITS > tpfe_pkg::BASE_BITS) ?
		DURATION_BITS : tpfe_pkg::BASE_BITS;
	localparam logic [WIDE-1:0] MAX_DUR = WIDE'({DURATION_BITS{1'b1}});

	logic [tpfe_pkg::UNIT_BITS-1:0] unit_q;
	logic [tpfe_pkg::IDX_BITS-1:0]  ctr_q;
	logic                           out_valid_q;
	logic                           level_q;
	logic [DURATION_BITS-1:0]       duration_q;
	logic                           last_q;

	logic                           load;
	logic                           at_last;
	logic                           bit_sel;
	logic [1:0]                     shift;
	logic [tpfe_pkg::BASE_BITS-1:0] raw_dur;
	logic [WIDE-1:0]                wide_dur;
	logic [DURATION_BITS-1:0]       sat_dur;

	assign cfg_ch.ready = 1'b1;

	assign load    = head_valid && (!out_valid_q || rec_ch.ready);
	assign at_last = (ctr_q == head.last_idx);
	assign pop     = load && at_last;

	// bits mode: record index = {bit[3:0], phase[1:0]}; phases 0/1 carry 2u for a one
	assign bit_sel = head.payload[ctr_q[5:2]];

	always_comb begin
		case (head.mode)
			tpfe_pkg::MODE_BITS:  shift = (!ctr_q[1] && bit_sel) ?
				tpfe_pkg::SHIFT_2U : tpfe_pkg::SHIFT_1U;
			tpfe_pkg::MODE_CYCLE: shift = head.shift;
			default:              shift = tpfe_pkg::SHIFT_1U;
		endcase
	end

	assign raw_dur  = {3'b000, unit_q} << shift;
	assign wide_dur = WIDE'(raw_dur);
	assign sat_dur  = (wide_dur > MAX_DUR) ? {DURATION_BITS{1'b1}} : wide_dur[DURATION_BITS-1:0];

	always_ff @(posedge clk) begin
		if (load) begin
			level_q    <= !ctr_q[0];
			duration_q <= sat_dur;
			last_q     <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q      <= tpfe_pkg::UNIT_RESET;
			ctr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_ch.valid) begin
				unit_q <= cfg_ch.unit_length;
			end
			if (load) begin
				ctr_q       <= at_last ? '0 : ctr_q + 6'd1;
				out_valid_q <= 1'b1;
			end else if (rec_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rec_ch.valid    = out_valid_q;
	assign rec_ch.level    = level_q;
	assign rec_ch.duration = duration_q;
	assign rec_ch.last     = last_q;

endmodule
